// ----- design/i2cms_pkg.sv -----
// Package for the I2C master transaction sequencer.
// Holds the item and result types, the code enums and the status constants.
// Used by i2cms_core and the top module; depends on nothing.
package i2cms_pkg;

  localparam int WRITE_DEPTH = 64;
  localparam int WPTR_W      = (WRITE_DEPTH > 1) ? $clog2(WRITE_DEPTH) : 1;
  localparam int WLEFT_W     = $clog2(WRITE_DEPTH + 1);
  localparam int RCOUNT_W    = 15;

  // Controller status codes, low three bits masked off.
  localparam logic [7:0] ST_MASK          = 8'hf8;
  localparam logic [7:0] ST_START         = 8'h08;
  localparam logic [7:0] ST_REP_START     = 8'h10;
  localparam logic [7:0] ST_ADDR_W_ACK    = 8'h18;
  localparam logic [7:0] ST_DATA_W_ACK    = 8'h28;
  localparam logic [7:0] ST_ADDR_W_NACK   = 8'h20;
  localparam logic [7:0] ST_DATA_W_NACK   = 8'h30;
  localparam logic [7:0] ST_ADDR_R_NACK   = 8'h48;
  localparam logic [7:0] ST_ARB_LOST      = 8'h38;
  localparam logic [7:0] ST_ADDR_R_ACK    = 8'h40;
  localparam logic [7:0] ST_DATA_R_ACK    = 8'h50;
  localparam logic [7:0] ST_DATA_R_NACK   = 8'h58;

  typedef enum logic [1:0] {
    KIND_START  = 2'd0,
    KIND_LOAD   = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    MODE_IDLE       = 2'd0,
    MODE_WRITE      = 2'd1,
    MODE_READ       = 2'd2,
    MODE_WRITE_READ = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ACK_KEEP = 2'd0,
    ACK_ACK  = 2'd1,
    ACK_NACK = 2'd2
  } ack_t;

  typedef enum logic [1:0] {
    DONE_WRITE    = 2'd0,
    DONE_READ     = 2'd1,
    DONE_NO_ACK   = 2'd2,
    DONE_ARB_LOST = 2'd3
  } done_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic [1:0]          mode;
    logic [7:0]          device_address;
    logic [6:0]          write_count;
    logic [RCOUNT_W-1:0] read_count;
    logic [5:0]          load_index;
    logic [7:0]          load_byte;
    logic [7:0]          bus_status;
    logic [7:0]          received_byte;
  } item_t;

  typedef struct packed {
    logic                send_valid;
    logic [7:0]          send_byte;
    logic                request_start;
    logic                request_stop;
    logic [1:0]          ack_action;
    logic                clear_flags;
    logic                read_valid;
    logic [7:0]          read_byte;
    logic                done_res;
    logic [1:0]          done_code;
    logic [RCOUNT_W-1:0] bytes_read;
  } result_t;

  typedef struct packed {
    logic              we;
    logic [WPTR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic [WPTR_W-1:0] raddr;
  } store_req_t;

endpackage

// ----- design/i2cms_ram.sv -----
// Generic single write port RAM with one registered read port.
// Used for the write byte store; depends on nothing.
module i2cms_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/i2cms_core.sv -----
// Transaction state and per-item decode for the I2C master sequencer.
// Turns one item into one result and drives the write store port.
// Depends on i2cms_pkg.
module i2cms_core
  import i2cms_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  item_t      item,
  input  logic [7:0] store_byte,
  output result_t    result,
  output store_req_t store_req
);

  mode_t               active_mode, active_mode_next;
  logic [7:0]          address_byte, address_byte_next;
  logic [WLEFT_W-1:0]  writes_left, writes_left_next;
  logic [RCOUNT_W-1:0] reads_left, reads_left_next;
  logic [RCOUNT_W-1:0] reads_requested, reads_requested_next;
  logic [WPTR_W-1:0]   write_pointer, write_pointer_next;

  logic [RCOUNT_W-1:0] reads_left_dec;
  logic [WLEFT_W-1:0]  write_count_sat;
  logic [WPTR_W-1:0]   pointer_inc;

  assign reads_left_dec  = (reads_left != '0) ? reads_left - 1'b1 : reads_left;
  assign write_count_sat = (32'(item.write_count) > WRITE_DEPTH) ?
                           WLEFT_W'(WRITE_DEPTH) : WLEFT_W'(item.write_count);
  assign pointer_inc     = (32'(write_pointer) == WRITE_DEPTH - 1) ?
                           '0 : write_pointer + 1'b1;

  always_comb begin
    result               = '0;
    store_req.we         = 1'b0;
    store_req.waddr      = WPTR_W'(item.load_index);
    store_req.wdata      = item.load_byte;
    active_mode_next     = active_mode;
    address_byte_next    = address_byte;
    writes_left_next     = writes_left;
    reads_left_next      = reads_left;
    reads_requested_next = reads_requested;
    write_pointer_next   = write_pointer;

    unique case (kind_t'(item.kind))
      KIND_START: begin
        if (mode_t'(item.mode) != MODE_IDLE) begin
          active_mode_next = mode_t'(item.mode);
          if (mode_t'(item.mode) == MODE_READ) begin
            address_byte_next = {item.device_address[7:1], 1'b1};
            writes_left_next  = '0;
          end else begin
            address_byte_next = {item.device_address[7:1], 1'b0};
            writes_left_next  = write_count_sat;
          end
          reads_requested_next = (mode_t'(item.mode) == MODE_WRITE) ? '0 : item.read_count;
          reads_left_next      = (mode_t'(item.mode) == MODE_WRITE) ? '0 : item.read_count;
          write_pointer_next   = '0;
          result.clear_flags   = 1'b1;
          result.request_start = 1'b1;
          result.ack_action    = ACK_ACK;
        end
      end
      KIND_LOAD: begin
        store_req.we = fire && (32'(item.load_index) < WRITE_DEPTH);
      end
      KIND_STATUS: begin
        result.clear_flags = 1'b1;
        if (active_mode != MODE_IDLE) begin
          unique case (item.bus_status & ST_MASK)
            ST_START, ST_REP_START: begin
              result.send_valid = 1'b1;
              result.send_byte  = address_byte;
            end
            ST_ADDR_W_ACK, ST_DATA_W_ACK: begin
              if (writes_left != '0) begin
                result.send_valid  = 1'b1;
                result.send_byte   = store_byte;
                write_pointer_next = pointer_inc;
                writes_left_next   = writes_left - 1'b1;
              end else if (active_mode == MODE_WRITE_READ) begin
                // Switch to the read phase with a repeated start.
                address_byte_next    = {address_byte[7:1], 1'b1};
                result.request_start = 1'b1;
                result.ack_action    = ACK_ACK;
              end else begin
                // Write-only transfer ends here, with no stop and no flag clear.
                result.clear_flags = 1'b0;
                result.done_res    = 1'b1;
                result.done_code   = DONE_WRITE;
                result.bytes_read  = reads_requested - reads_left;
                active_mode_next   = MODE_IDLE;
              end
            end
            ST_ADDR_W_NACK, ST_DATA_W_NACK, ST_ADDR_R_NACK: begin
              result.request_stop = 1'b1;
              result.done_res     = 1'b1;
              result.done_code    = DONE_NO_ACK;
              result.bytes_read   = reads_requested - reads_left;
              active_mode_next    = MODE_IDLE;
            end
            ST_ARB_LOST: begin
              result.done_res   = 1'b1;
              result.done_code  = DONE_ARB_LOST;
              result.bytes_read = reads_requested - reads_left;
              active_mode_next  = MODE_IDLE;
            end
            ST_ADDR_R_ACK: begin
              result.ack_action = (reads_left <= RCOUNT_W'(1)) ? ACK_NACK : ACK_ACK;
            end
            ST_DATA_R_ACK: begin
              result.read_valid = 1'b1;
              result.read_byte  = item.received_byte;
              reads_left_next   = reads_left_dec;
              if (reads_left_dec <= RCOUNT_W'(1)) begin
                result.ack_action = ACK_NACK;
              end
            end
            ST_DATA_R_NACK: begin
              result.read_valid   = 1'b1;
              result.read_byte    = item.received_byte;
              reads_left_next     = reads_left_dec;
              result.request_stop = 1'b1;
              result.done_res     = 1'b1;
              result.done_code    = DONE_READ;
              result.bytes_read   = reads_requested - reads_left_dec;
              active_mode_next    = MODE_IDLE;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
      end
    endcase

    // The store is read ahead at the pointer the next item will see.
    store_req.raddr = fire ? write_pointer_next : write_pointer;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_mode     <= MODE_IDLE;
      address_byte    <= '0;
      writes_left     <= '0;
      reads_left      <= '0;
      reads_requested <= '0;
      write_pointer   <= '0;
    end else if (fire) begin
      active_mode     <= active_mode_next;
      address_byte    <= address_byte_next;
      writes_left     <= writes_left_next;
      reads_left      <= reads_left_next;
      reads_requested <= reads_requested_next;
      write_pointer   <= write_pointer_next;
    end
  end

endmodule

// ----- design/i2c_master_transaction_sequencer.sv -----
// I2C master transaction sequencer. Every request (start, store load or bus status) gives
// exactly one result once it is taken, held first in the input register and then in the
// result register. A new request is taken in every cycle while results are being taken.
// The 64-byte write store is a RAM read ahead at the next send position, with
// same-cycle load forwarding, so store sends run at full rate; the store has no clearing
// pass and entries never loaded read as anything.
// Depends on i2cms_pkg, i2cms_core and i2cms_ram.
module i2c_master_transaction_sequencer
  import i2cms_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // mode[1:0], device_address[9:2], write_count[16:10], read_count[31:17],
  // load_index[37:32], load_byte[45:38], bus_status[53:46], received_byte[61:54]
  input  logic [63:0] s_tdata,
  // kind[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // send_valid[0], send_byte[8:1], request_start[9], request_stop[10],
  // ack_action[12:11], clear_flags[13], read_valid[14], read_byte[22:15],
  // done_res[23], done_code[25:24], bytes_read[40:26]
  output logic [47:0] m_tdata
);

  logic       s1_valid;
  item_t      s1_item;
  logic       advance;
  logic       fire;
  result_t    result;
  result_t    out_result;
  store_req_t store_req;
  logic [7:0] ram_q;
  logic       fwd_hit;
  logic [7:0] fwd_byte;
  logic [7:0] store_byte;

  assign advance  = !m_tvalid || m_tready;
  assign fire     = s1_valid && advance;
  assign s_tready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      s1_item.kind           <= s_tuser;
      s1_item.mode           <= s_tdata[1:0];
      s1_item.device_address <= s_tdata[9:2];
      s1_item.write_count    <= s_tdata[16:10];
      s1_item.read_count     <= s_tdata[31:17];
      s1_item.load_index     <= s_tdata[37:32];
      s1_item.load_byte      <= s_tdata[45:38];
      s1_item.bus_status     <= s_tdata[53:46];
      s1_item.received_byte  <= s_tdata[61:54];
    end
  end

  i2cms_core u_core (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .item       (s1_item),
    .store_byte (store_byte),
    .result     (result),
    .store_req  (store_req)
  );

  i2cms_ram #(
    .WIDTH  (8),
    .DEPTH  (WRITE_DEPTH),
    .ADDR_W (WPTR_W)
  ) u_store (
    .clk   (clk),
    .we    (store_req.we),
    .waddr (store_req.waddr),
    .wdata (store_req.wdata),
    .raddr (store_req.raddr),
    .rdata (ram_q)
  );

  // A load to the entry being read in the same cycle is passed round the RAM.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else begin
      fwd_hit <= store_req.we && (store_req.waddr == store_req.raddr);
    end
  end

  always_ff @(posedge clk) begin
    fwd_byte <= store_req.wdata;
  end

  assign store_byte = fwd_hit ? fwd_byte : ram_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_result <= result;
    end
  end

  assign m_tdata = {7'd0,
                    out_result.bytes_read,
                    out_result.done_code,
                    out_result.done_res,
                    out_result.read_byte,
                    out_result.read_valid,
                    out_result.clear_flags,
                    out_result.ack_action,
                    out_result.request_stop,
                    out_result.request_start,
                    out_result.send_byte,
                    out_result.send_valid};

endmodule
